// File: sv/polygon_point_location_defines.svh
// ----------------------------------------------------------------------------
// polygon_point_location_defines
// Assertion macros for the point-location block; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef POLYGON_POINT_LOCATION_DEFINES_SVH
`define POLYGON_POINT_LOCATION_DEFINES_SVH

`ifndef SYNTH
// check a property on every clock edge outside reset
`define PPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that a condition never holds outside reset
`define PPL_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PPL_ASSERT(lbl, prop, msg)
`define PPL_NEVER(lbl, expr, msg)
`endif

`endif

// File: sv/ppl_pkg.sv
// ----------------------------------------------------------------------------
// ppl_pkg
// Shared widths, codes and types of the point-in-polygon edge chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ppl_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;
  localparam int IDX_WIDTH    = 6;
  localparam int CNT_WIDTH    = 7;
  localparam int LOC_WIDTH    = 2;

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int WN_W    = $clog2(MAX_VERTICES + 1) + 1;

  localparam int CELL_STAGES = 3;
  localparam int CHAIN_DEPTH = CELL_STAGES * MAX_VERTICES;
  localparam int INFL_W      = $clog2(CHAIN_DEPTH + 1);

  localparam int NV_W  = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W = (CNT_WIDTH > NV_W) ? CNT_WIDTH : NV_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [LOC_WIDTH-1:0] LOC_BOUNDARY = 2'd0;
  localparam logic [LOC_WIDTH-1:0] LOC_OUTSIDE  = 2'd1;
  localparam logic [LOC_WIDTH-1:0] LOC_INSIDE   = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } vtx_t;

  // query word as it travels along the chain
  typedef struct packed {
    vtx_t                   pt;
    logic signed [WN_W-1:0] wn;
    logic                   bnd;
  } tok_t;

endpackage

`default_nettype wire

// File: sv/ppl_cell.sv
// ----------------------------------------------------------------------------
// ppl_cell
// One edge cell: holds vertex i, tests a passing query word against the edge
// from vertex i to the next vertex in three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ppl_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  adv,
  input  wire                  wr_en,
  input  wire ppl_pkg::vtx_t   wr_vtx,
  input  wire                  active,
  input  wire ppl_pkg::vtx_t   nxt_vtx,
  input  wire                  vld_in,
  input  wire ppl_pkg::tok_t   tok_in,
  output ppl_pkg::vtx_t        vtx,
  output logic                 vld_out,
  output ppl_pkg::tok_t        tok_out
);

  ppl_pkg::vtx_t vtx_r;

  // stage 1
  logic                                  vld1_r;
  ppl_pkg::tok_t                         tok1_r;
  ppl_pkg::tok_t                         tok1_nxt;
  logic                                  cross1_r, below1_r;
  logic signed [ppl_pkg::DIFF_W-1:0]     dxe1_r, dyp1_r, dye1_r, dxp1_r;
  logic                                  bnd1_nxt, cross1_nxt, below1_nxt;
  logic                                  hit, horiz, on_span;
  logic signed [ppl_pkg::DIFF_W-1:0]     dxe1_nxt, dyp1_nxt, dye1_nxt, dxp1_nxt;

  // stage 2
  logic                                  vld2_r;
  ppl_pkg::tok_t                         tok2_r;
  logic                                  cross2_r, below2_r;
  logic signed [ppl_pkg::PROD_W-1:0]     p1_r, p2_r;

  // stage 3
  logic                                  vld3_r;
  ppl_pkg::tok_t                         tok3_r;
  ppl_pkg::tok_t                         tok3_nxt;
  logic signed [ppl_pkg::CROSS_W-1:0]    cross_val;
  logic                                  c_pos, c_neg, c_zero;

  assign vtx = vtx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vtx_r <= wr_vtx;
    end
  end

  always_comb begin
    hit     = (vtx_r.x == tok_in.pt.x) && (vtx_r.y == tok_in.pt.y);
    horiz   = (vtx_r.y == tok_in.pt.y) && (nxt_vtx.y == tok_in.pt.y);
    on_span = ((vtx_r.x <= tok_in.pt.x) || (nxt_vtx.x <= tok_in.pt.x)) &&
              ((tok_in.pt.x <= vtx_r.x) || (tok_in.pt.x <= nxt_vtx.x));
    below1_nxt = vtx_r.y < tok_in.pt.y;
    cross1_nxt = active && !horiz && (below1_nxt != (nxt_vtx.y < tok_in.pt.y));
    bnd1_nxt   = tok_in.bnd || (active && (hit || (horiz && on_span)));
    dxe1_nxt   = ppl_pkg::DIFF_W'(nxt_vtx.x) - ppl_pkg::DIFF_W'(vtx_r.x);
    dyp1_nxt   = ppl_pkg::DIFF_W'(tok_in.pt.y) - ppl_pkg::DIFF_W'(vtx_r.y);
    dye1_nxt   = ppl_pkg::DIFF_W'(nxt_vtx.y) - ppl_pkg::DIFF_W'(vtx_r.y);
    dxp1_nxt   = ppl_pkg::DIFF_W'(tok_in.pt.x) - ppl_pkg::DIFF_W'(vtx_r.x);
    tok1_nxt     = tok_in;
    tok1_nxt.bnd = bnd1_nxt;
  end

  always_comb begin
    cross_val = ppl_pkg::CROSS_W'(p1_r) - ppl_pkg::CROSS_W'(p2_r);
    c_zero    = cross_val == '0;
    c_neg     = cross_val[ppl_pkg::CROSS_W-1];
    c_pos     = !c_neg && !c_zero;
    tok3_nxt      = tok2_r;
    tok3_nxt.bnd  = tok2_r.bnd || (cross2_r && c_zero);
    // upward crossing with the point on the left adds, downward on the right drops
    if (cross2_r && below2_r && c_pos) begin
      tok3_nxt.wn = tok2_r.wn + ppl_pkg::WN_W'(1);
    end else if (cross2_r && !below2_r && c_neg) begin
      tok3_nxt.wn = tok2_r.wn - ppl_pkg::WN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok1_r     <= tok1_nxt;
      cross1_r   <= cross1_nxt;
      below1_r   <= below1_nxt;
      dxe1_r     <= dxe1_nxt;
      dyp1_r     <= dyp1_nxt;
      dye1_r     <= dye1_nxt;
      dxp1_r     <= dxp1_nxt;

      tok2_r     <= tok1_r;
      cross2_r   <= cross1_r;
      below2_r   <= below1_r;
      p1_r       <= ppl_pkg::PROD_W'(dxe1_r) * ppl_pkg::PROD_W'(dyp1_r);
      p2_r       <= ppl_pkg::PROD_W'(dye1_r) * ppl_pkg::PROD_W'(dxp1_r);

      tok3_r     <= tok3_nxt;
    end
  end

  assign vld_out = vld3_r;
  assign tok_out = tok3_r;

endmodule

`default_nettype wire

// File: sv/polygon_point_location.sv
// Point-in-polygon classifier by the winding-number rule. Vertices live in a
// row of MAX_VERTICES edge cells; a query word walks the row, each cell
// testing it against its own edge in three register stages, and passes
// every cell and then the result register, whatever vertex_count is. Queries
// stream into the row at one per cycle while the result side keeps up; a
// stalled result stalls the whole row. A load is held off until every query
// has left the row, since the cells read their vertices throughout a query's
// walk. There is no clearing pass after reset; the vertex store is undefined
// until loaded.

// ----------------------------------------------------------------------------
// polygon_point_location
// Top level: load/query decode, edge-cell chain, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polygon_point_location_defines.svh"

module polygon_point_location (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_wr_en,
  input  wire [ppl_pkg::CNT_WIDTH-1:0]         cfg_wr_data,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_cmd,
  input  wire [ppl_pkg::IDX_WIDTH-1:0]         in_vertex_index,
  input  wire signed [ppl_pkg::COORD_WIDTH-1:0] in_coord_x,
  input  wire signed [ppl_pkg::COORD_WIDTH-1:0] in_coord_y,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [ppl_pkg::LOC_WIDTH-1:0]        out_location
);

  logic [ppl_pkg::CNT_WIDTH-1:0] count_r;
  logic [ppl_pkg::CMP_W-1:0]     cnt_ext, n_eff;
  logic [ppl_pkg::INFL_W-1:0]    inflight_r, inflight_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ppl_pkg::LOC_WIDTH-1:0] location_r, location_nxt;
  logic                          adv, query_acc, load_acc;
  ppl_pkg::vtx_t                 in_vtx;
  ppl_pkg::tok_t                 head_tok;

  ppl_pkg::vtx_t vtx  [ppl_pkg::MAX_VERTICES];
  ppl_pkg::tok_t tok  [ppl_pkg::MAX_VERTICES+1];
  logic          vld  [ppl_pkg::MAX_VERTICES+1];

  // advance the row whenever the result register is free or being emptied
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = (in_cmd == ppl_pkg::CMD_QUERY) ? adv : (inflight_r == '0);
  assign query_acc = in_valid && in_ready && (in_cmd == ppl_pkg::CMD_QUERY);
  assign load_acc  = in_valid && in_ready && (in_cmd == ppl_pkg::CMD_LOAD);

  assign cnt_ext = ppl_pkg::CMP_W'(count_r);
  assign n_eff   = (cnt_ext > ppl_pkg::CMP_W'(ppl_pkg::MAX_VERTICES)) ?
                   ppl_pkg::CMP_W'(ppl_pkg::MAX_VERTICES) : cnt_ext;

  always_comb begin
    in_vtx.x     = in_coord_x;
    in_vtx.y     = in_coord_y;
    head_tok.pt  = in_vtx;
    head_tok.wn  = '0;
    head_tok.bnd = 1'b0;
  end

  assign vld[0] = query_acc;
  assign tok[0] = head_tok;

  for (genvar i = 0; i < ppl_pkg::MAX_VERTICES; i++) begin : g_cell
    ppl_pkg::vtx_t nxt;
    logic          active, wr_en;

    // wrap the last edge in use back to vertex 0
    if (i == ppl_pkg::MAX_VERTICES - 1) begin : g_last
      assign nxt = vtx[0];
    end else begin : g_mid
      assign nxt = (ppl_pkg::CMP_W'(i + 1) == n_eff) ? vtx[0] : vtx[i+1];
    end

    assign active = ppl_pkg::CMP_W'(i) < n_eff;
    assign wr_en  = load_acc && (int'(in_vertex_index) == i);

    ppl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr_en   (wr_en),
      .wr_vtx  (in_vtx),
      .active  (active),
      .nxt_vtx (nxt),
      .vld_in  (vld[i]),
      .tok_in  (tok[i]),
      .vtx     (vtx[i]),
      .vld_out (vld[i+1]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    location_nxt = location_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = vld[ppl_pkg::MAX_VERTICES];
      if (tok[ppl_pkg::MAX_VERTICES].bnd) begin
        location_nxt = ppl_pkg::LOC_BOUNDARY;
      end else if (tok[ppl_pkg::MAX_VERTICES].wn != '0) begin
        location_nxt = ppl_pkg::LOC_INSIDE;
      end else begin
        location_nxt = ppl_pkg::LOC_OUTSIDE;
      end
    end
  end

  always_comb begin
    inflight_nxt = inflight_r;
    if (query_acc && !(adv && vld[ppl_pkg::MAX_VERTICES])) begin
      inflight_nxt = inflight_r + ppl_pkg::INFL_W'(1);
    end else if (!query_acc && adv && vld[ppl_pkg::MAX_VERTICES]) begin
      inflight_nxt = inflight_r - ppl_pkg::INFL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      inflight_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      inflight_r  <= inflight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    location_r <= location_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_location = location_r;

  `PPL_NEVER(a_infl_range, inflight_r > ppl_pkg::INFL_W'(ppl_pkg::CHAIN_DEPTH), "query count exceeds row depth")
  `PPL_ASSERT(a_empty_tail, (inflight_r == '0) |-> !vld[ppl_pkg::MAX_VERTICES], "result word with no query in flight")
  `PPL_ASSERT(a_stall_hold, !adv |=> (inflight_r == $past(inflight_r)), "query count moved during stall")
  `PPL_NEVER(a_load_busy, load_acc && (inflight_r != '0), "vertex load while queries in flight")

endmodule

`default_nettype wire

// File: sim/ppl_location_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppl_location_checker
// Watches the load/query channel, keeps its own polygon and vertex count,
// works out the location of every query point and compares it with each
// result word in order of arrival.
// ----------------------------------------------------------------------------
module ppl_location_checker (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_wr_en,
  input  wire [ppl_pkg::CNT_WIDTH-1:0]          cfg_wr_data,
  input  wire                                   in_valid,
  input  wire                                   in_ready,
  input  wire                                   in_cmd,
  input  wire [ppl_pkg::IDX_WIDTH-1:0]          in_vertex_index,
  input  wire signed [ppl_pkg::COORD_WIDTH-1:0] in_coord_x,
  input  wire signed [ppl_pkg::COORD_WIDTH-1:0] in_coord_y,
  input  wire                                   out_valid,
  input  wire                                   out_ready,
  input  wire [ppl_pkg::LOC_WIDTH-1:0]          out_location,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    n_boundary,
  output int                                    n_outside,
  output int                                    n_inside
);
  import ppl_pkg::*;

  vtx_t                 poly_store [MAX_VERTICES];
  logic [CNT_WIDTH-1:0] poly_count;
  logic [LOC_WIDTH-1:0] expected_locations [$];

  // winding-number classification of one point against the stored polygon
  function automatic logic [LOC_WIDTH-1:0] locate_point(input longint px, input longint py);
    int     n;
    int     i;
    int     j;
    int     wn;
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint cprod;
    logic   below;
    n  = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    wn = 0;
    for (i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      ax = $signed(poly_store[i].x);
      ay = $signed(poly_store[i].y);
      bx = $signed(poly_store[j].x);
      by = $signed(poly_store[j].y);
      if (ax == px && ay == py) return LOC_BOUNDARY;
      if (ay == py && by == py) begin
        if (((ax < bx) ? ax : bx) <= px && px <= ((ax < bx) ? bx : ax)) return LOC_BOUNDARY;
      end else begin
        below = (ay < py);
        if (below != (by < py)) begin
          cprod = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
          if (cprod == 0) return LOC_BOUNDARY;
          if (below == (cprod > 0)) wn += below ? 1 : -1;
        end
      end
    end
    return (wn == 0) ? LOC_OUTSIDE : LOC_INSIDE;
  endfunction

  always @(posedge clk) begin
    logic [LOC_WIDTH-1:0] want;
    if (!rst_n) begin
      poly_count = '0;
      fail_count = 0;
      pending    = 0;
      n_boundary = 0;
      n_outside  = 0;
      n_inside   = 0;
      expected_locations.delete();
    end else begin
      if (cfg_wr_en) poly_count = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_locations.size() == 0) begin
          $error("location: no result expected, actual %0d", out_location);
          fail_count++;
        end else begin
          want = expected_locations.pop_front();
          if (out_location !== want) begin
            $error("location mismatch: expected %0d, actual %0d", want, out_location);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_LOAD) begin
          poly_store[in_vertex_index].x = in_coord_x;
          poly_store[in_vertex_index].y = in_coord_y;
        end else begin
          want = locate_point(in_coord_x, in_coord_y);
          expected_locations.insert(expected_locations.size(), want);
          if (want == LOC_BOUNDARY) n_boundary++;
          else if (want == LOC_OUTSIDE) n_outside++;
          else n_inside++;
        end
      end
      pending = expected_locations.size();
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Point-in-polygon classifier: loads polygons of many shapes and sizes,
// fires query points at vertices, edges, interiors and at random, with
// random gaps on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import ppl_pkg::*;

  localparam int LATENCY        = CELL_STAGES * MAX_VERTICES + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 450;

  typedef enum int {STYLE_FULL, STYLE_BOX, STYLE_GRID, STYLE_CORNER} coord_style_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CNT_WIDTH-1:0]   cfg_wr_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_cmd;
  logic [IDX_WIDTH-1:0]   in_vertex_index;
  logic [COORD_WIDTH-1:0] in_coord_x;
  logic [COORD_WIDTH-1:0] in_coord_y;
  logic                   out_valid;
  logic                   out_ready;
  logic [LOC_WIDTH-1:0]   out_location;

  int chk_fails;
  int chk_pending;
  int chk_boundary;
  int chk_outside;
  int chk_inside;

  // stimulus-side copy of the loaded shape, used only to aim query points
  logic [COORD_WIDTH-1:0] shape_x [MAX_VERTICES];
  logic [COORD_WIDTH-1:0] shape_y [MAX_VERTICES];

  coord_style_t coord_style;
  int           box_r;
  int           grid_x [3];
  int           grid_y [3];
  bit           tx_eager;
  bit           rx_eager;
  int           loads_sent;
  int           queries_sent;
  int           settings_used;
  int           random_words;
  int           idle_cycles;
  logic         rx_fire;
  int           rx_wait;

  polygon_point_location dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_location    (out_location)
  );

  ppl_location_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_location    (out_location),
    .fail_count      (chk_fails),
    .pending         (chk_pending),
    .n_boundary      (chk_boundary),
    .n_outside       (chk_outside),
    .n_inside        (chk_inside)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: after each word taken, hold ready low for a drawn number of valid cycles
  always @(posedge clk) rx_fire <= out_valid && out_ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (rx_fire === 1'b1) rx_wait = rx_eager ? 0 : $urandom_range(0, 6);
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        if (out_valid) rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_word(input logic cmd, input int idx, input int x, input int y);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_vertex_index <= idx[IDX_WIDTH-1:0];
    in_coord_x      <= x[COORD_WIDTH-1:0];
    in_coord_y      <= y[COORD_WIDTH-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_vertex(input int idx, input int x, input int y);
    send_word(CMD_LOAD, idx, x, y);
    shape_x[idx[IDX_WIDTH-1:0]] = x[COORD_WIDTH-1:0];
    shape_y[idx[IDX_WIDTH-1:0]] = y[COORD_WIDTH-1:0];
    loads_sent++;
  endtask

  task automatic query_point(input int x, input int y);
    send_word(CMD_QUERY, $urandom_range(0, 63), x, y);
    queries_sent++;
  endtask

  // hold the sender until every result is back, then let the row settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic set_count(input int n);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n[CNT_WIDTH-1:0];
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  function automatic int pick_coord(input bit is_y);
    int v;
    case (coord_style)
      STYLE_FULL: v = int'($urandom_range(0, 65535)) - 32768;
      STYLE_BOX:  v = int'($urandom_range(0, 2 * box_r)) - box_r;
      STYLE_GRID: v = is_y ? grid_y[$urandom_range(0, 2)] : grid_x[$urandom_range(0, 2)];
      default: begin
        case ($urandom_range(0, 6))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = 32766;
          default: v = 32767;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  task automatic random_word(input int neff);
    int     r;
    int     k;
    int     j;
    int     i;
    longint sx;
    longint sy;
    r = $urandom_range(0, 9);
    if (neff == 0 && r < 6) r = 6 + $urandom_range(0, 3);
    k = (neff > 0) ? $urandom_range(0, neff - 1) : 0;
    j = (k + 1 >= neff) ? 0 : k + 1;
    case (r)
      0, 1: query_point($signed(shape_x[k]), $signed(shape_y[k]));
      2: begin
        // exact midpoint lands on the edge when both spans are even
        sx = (longint'($signed(shape_x[k])) + longint'($signed(shape_x[j]))) >>> 1;
        sy = (longint'($signed(shape_y[k])) + longint'($signed(shape_y[j]))) >>> 1;
        query_point(int'(sx), int'(sy));
      end
      3: query_point(clamp16(longint'($signed(shape_x[k])) + $urandom_range(0, 2) - 1),
                     clamp16(longint'($signed(shape_y[k])) + $urandom_range(0, 2) - 1));
      4, 5: begin
        sx = 0;
        sy = 0;
        for (i = 0; i < neff; i++) begin
          sx += $signed(shape_x[i]);
          sy += $signed(shape_y[i]);
        end
        query_point(clamp16(sx / neff + int'($urandom_range(0, 6)) - 3),
                    clamp16(sy / neff + int'($urandom_range(0, 6)) - 3));
      end
      6: load_vertex($urandom_range(0, 63), pick_coord(0), pick_coord(1));
      7, 8: query_point(pick_coord(0), pick_coord(1));
      default: query_point(int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768);
    endcase
  endtask

  initial begin
    int phase;
    int cnt;
    int neff;
    int nq;
    int k;
    bit downward;
    in_valid        = 1'b0;
    in_cmd          = CMD_LOAD;
    in_vertex_index = '0;
    in_coord_x      = '0;
    in_coord_y      = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    rst_n           = 1'b0;
    tx_eager        = 1'b0;
    rx_eager        = 1'b0;
    coord_style     = STYLE_FULL;
    box_r           = 1;
    loads_sent      = 0;
    queries_sent    = 0;
    settings_used   = 0;
    random_words    = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // empty polygon: no edges, everything is outside
    set_count(0);
    query_point(-32768, 32767);
    query_point(0, 0);

    // right triangle spanning nearly the full coordinate range
    set_count(3);
    load_vertex(0, -32768, -32768);
    load_vertex(1, 32766, -32768);
    load_vertex(2, -32768, 32766);
    query_point(32766, -32768);   // on a vertex
    query_point(0, -32768);       // on the horizontal edge
    query_point(-1, -1);          // on the slanted edge
    query_point(-32768, 0);       // on the vertical edge
    query_point(-100, -100);
    query_point(32767, 32767);
    query_point(32767, -32768);   // level with the horizontal edge, past its end
    load_vertex(63, 32767, -1);

    // single point
    set_count(1);
    query_point(-32768, -32768);
    query_point(5, 5);

    // doubled segment
    set_count(2);
    load_vertex(1, 100, 300);
    query_point(-16334, -16234);
    query_point(-16334, -16233);

    phase = 0;
    while (random_words < RANDOM_ITEMS) begin
      if (phase == 0) cnt = MAX_VERTICES;
      else if (phase == 1) cnt = 127;   // beyond the store, clipped to its size
      else begin
        case ($urandom_range(0, 19))
          0, 1:    cnt = $urandom_range(0, 2);
          2:       cnt = MAX_VERTICES;
          3:       cnt = $urandom_range(MAX_VERTICES + 1, 127);
          default: cnt = $urandom_range(3, 10);
        endcase
      end
      set_count(cnt);
      neff        = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
      tx_eager    = ($urandom_range(0, 3) == 0);
      rx_eager    = ($urandom_range(0, 3) == 0);
      coord_style = coord_style_t'($urandom_range(0, 3));
      box_r       = $urandom_range(1, 60);
      for (k = 0; k < 3; k++) begin
        grid_x[k] = int'($urandom_range(0, 65535)) - 32768;
        grid_y[k] = int'($urandom_range(0, 65535)) - 32768;
      end
      downward = $urandom_range(0, 1);
      for (k = 0; k < neff; k++) begin
        load_vertex(downward ? neff - 1 - k : k, pick_coord(0), pick_coord(1));
        random_words++;
      end
      nq = (neff > 16) ? $urandom_range(6, 16) : $urandom_range(8, 30);
      for (k = 0; k < nq; k++) begin
        random_word(neff);
        random_words++;
      end
      phase++;
    end

    drain();
    @(negedge clk);
    $display("Covered %0d loads and %0d queries over %0d vertex-count settings",
             loads_sent, queries_sent, settings_used);
    $display("Query points by expected location: %0d boundary, %0d outside, %0d inside",
             chk_boundary, chk_outside, chk_inside);
    if (chk_fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
